/* sv/fpe_pkg.sv */
// Shared constants, twiddle generation and arctangent table of the phasor estimator.
`default_nettype none
package fpe_pkg;

  localparam int DEF_WINDOW_SAMPLES = 80;
  localparam int DEF_CHANNEL_COUNT = 8;
  localparam int DEF_ESTIMATES_PER_WINDOW = 4;

  localparam int IN_CHANNELS = 8;
  localparam int SAMPLE_W = 32;
  localparam int TW_W = 16;
  localparam int ACC_W = 64;
  localparam int MUL_W = 33;
  localparam int PROD_W = 66;
  localparam int ABS_W = 56;
  localparam int HALF_W = 28;
  localparam int ROOT_W = 58;
  localparam int RAD_W = 116;
  localparam int MAG_W = 40;
  localparam int PHASE_W = 16;
  localparam int CH_IDX_W = 3;
  localparam int CORDIC_STEPS = 15;
  localparam int STEP_W = 4;
  localparam longint CORDIC_START = 64'sd652032874;
  localparam int S_TDATA_W = IN_CHANNELS * SAMPLE_W;
  localparam int M_TDATA_W = 64;

  // Arctangent of 2^-i in units of pi/32768.
  function automatic logic [PHASE_W-1:0] arc_angle(input logic [STEP_W-1:0] i);
    logic [PHASE_W-1:0] a;
    case (i)
      4'd0: a = 16'd8192;
      4'd1: a = 16'd4836;
      4'd2: a = 16'd2555;
      4'd3: a = 16'd1297;
      4'd4: a = 16'd651;
      4'd5: a = 16'd326;
      4'd6: a = 16'd163;
      4'd7: a = 16'd81;
      4'd8: a = 16'd41;
      4'd9: a = 16'd20;
      4'd10: a = 16'd10;
      4'd11: a = 16'd5;
      4'd12: a = 16'd3;
      4'd13: a = 16'd1;
      4'd14: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Round Q2.30 to Q1.15 with saturation.
  function automatic logic [TW_W-1:0] to_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[TW_W-1:0];
  endfunction

  // Rotation CORDIC for one twiddle; returns {sin, cos} in Q1.15.
  function automatic logic [2*TW_W-1:0] twiddle_fn(input int ang);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    z = longint'(ang & 65535);
    flip = 1'b0;
    x = CORDIC_START;
    y = 64'sd0;
    if (z >= 64'sd32768) z = z - 64'sd65536;
    if (z > 64'sd16384) begin
      z = z - 64'sd32768;
      flip = 1'b1;
    end else if (z < -64'sd16384) begin
      z = z + 64'sd32768;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(arc_angle(STEP_W'(i)));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(arc_angle(STEP_W'(i)));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return {to_q15(y), to_q15(x)};
  endfunction

endpackage
`default_nettype wire

/* sv/fpe_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/fpe_mul.sv */
// Shared registered signed multiplier.
`default_nettype none
module fpe_mul (
  input  wire logic                        clk,
  input  wire logic signed [fpe_pkg::MUL_W-1:0]  a,
  input  wire logic signed [fpe_pkg::MUL_W-1:0]  b,
  output logic      signed [fpe_pkg::PROD_W-1:0] p
);
  import fpe_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

/* sv/fpe_root.sv */
// Bit-serial square root followed by rounding division by the window scale.
`default_nettype none
module fpe_root #(
  parameter int WINDOW_SAMPLES = fpe_pkg::DEF_WINDOW_SAMPLES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fpe_pkg::RAD_W-1:0]  radicand,
  output logic                            busy,
  output logic      [fpe_pkg::MAG_W-1:0]  magnitude
);
  import fpe_pkg::*;

  // strip the power-of-two factor from the divisor
  function automatic int odd_part(input int v);
    int r;
    r = v;
    while (r > 1 && !r[0]) r = r >> 1;
    return r;
  endfunction

  localparam int DIVISOR = 128 * WINDOW_SAMPLES;
  localparam int HALF_DIV = 64 * WINDOW_SAMPLES;
  localparam int ODD = odd_part(DIVISOR);
  localparam int SHIFT = $clog2(DIVISOR / ODD);
  localparam int DVD_W = ROOT_W + 1;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int ODD_W = 8;
  localparam int DIGIT_W = 13;
  localparam int DIGITS = 4;
  localparam int NUM_W = DIGIT_W * DIGITS;
  localparam int X_W = DIGIT_W + ODD_W;
  localparam int RECIP_S = 29;
  localparam int RECIP = ((1 << RECIP_S) + ODD - 1) / ODD;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_SQ = 2'd1;
  localparam logic [1:0] R_PRE = 2'd2;
  localparam logic [1:0] R_DIV = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  num;
  logic [ODD_W-1:0]  drem;
  logic [NUM_W-1:0]  quo;
  logic              mphase;

  logic [REM_W-1:0]         rem_try;
  logic [REM_W-1:0]         trial;
  logic [DVD_W-1:0]         dvd;
  logic [X_W-1:0]           x;
  logic [DIGIT_W-1:0]       qd;
  logic [X_W-1:0]           qd_m;
  logic [X_W-1:0]           x_left;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  assign rem_try = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign busy = (state != R_IDLE);
  assign magnitude = (|quo[NUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : quo[MAG_W-1:0];

  // round to nearest: add half the divisor once, then divide digit by digit
  assign dvd = {1'b0, root} + DVD_W'(HALF_DIV);
  assign x = {drem, num[NUM_W-1 -: DIGIT_W]};
  assign mul_a = MUL_W'(x);
  assign mul_b = MUL_W'(RECIP);
  assign qd = prod[RECIP_S +: DIGIT_W];
  assign qd_m = X_W'(qd) * X_W'(ODD);
  assign x_left = x - qd_m;

  fpe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      unique case (state)
        R_IDLE: begin
          if (start) begin
            rad <= radicand;
            rem <= '0;
            root <= '0;
            cnt <= '0;
            state <= R_SQ;
          end
        end
        R_SQ: begin
          rad <= {rad[RAD_W-3:0], 2'b00};
          if (rem_try >= trial) begin
            rem <= rem_try - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem <= rem_try;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            cnt <= '0;
            state <= R_PRE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        R_PRE: begin
          num <= NUM_W'(dvd >> SHIFT);
          drem <= '0;
          quo <= '0;
          mphase <= 1'b0;
          cnt <= '0;
          state <= R_DIV;
        end
        R_DIV: begin
          // while mphase is low the multiplier is fed; while it is high the quotient digit is taken
          if (!mphase) begin
            mphase <= 1'b1;
          end else begin
            mphase <= 1'b0;
            drem <= x_left[ODD_W-1:0];
            quo <= {quo[NUM_W-DIGIT_W-1:0], qd};
            num <= {num[NUM_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            if (cnt == CNT_W'(DIGITS - 1)) begin
              state <= R_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == R_SQ) |-> (cnt < CNT_W'(ROOT_W)))
    else $error("root iteration count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (busy && start) |=> busy)
    else $error("root unit dropped busy while restarted");

  assert property (@(posedge clk) disable iff (rst)
    (state == R_DIV) |-> (drem < ODD_W'(ODD)))
    else $error("division remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    (state == R_DIV) |-> (cnt < CNT_W'(DIGITS)))
    else $error("division digit count out of range");

endmodule
`default_nettype wire

/* sv/fpe_cordic.sv */
// Vectoring CORDIC: phase of (x, y), one micro-rotation per cycle.
`default_nettype none
module fpe_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [fpe_pkg::ACC_W-1:0] y_in,
  input  wire logic signed [fpe_pkg::ACC_W-1:0] x_in,
  output logic                               busy,
  output logic      [fpe_pkg::PHASE_W-1:0]   phase
);
  import fpe_pkg::*;

  logic                    run;
  logic [STEP_W-1:0]       step;
  logic signed [ACC_W-1:0] x;
  logic signed [ACC_W-1:0] y;
  logic signed [ACC_W-1:0] dx;
  logic signed [ACC_W-1:0] dy;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign busy = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (!run) begin
      if (start) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          phase <= '0;
        end else begin
          run <= 1'b1;
          if (x_in[ACC_W-1]) begin
            x <= -x_in;
            y <= -y_in;
            phase <= 16'h8000;
          end else begin
            x <= x_in;
            y <= y_in;
            phase <= '0;
          end
        end
      end
    end else begin
      if (!y[ACC_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        phase <= phase + arc_angle(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        phase <= phase - arc_angle(step);
      end
      if (step == STEP_W'(CORDIC_STEPS - 1)) begin
        run <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    run |-> (step < STEP_W'(CORDIC_STEPS)))
    else $error("cordic step out of range");

  assert property (@(posedge clk) disable iff (rst)
    (run && !y[ACC_W-1] && step != '0) |-> !x[ACC_W-1])
    else $error("cordic x went negative");

  assert property (@(posedge clk) disable iff (rst)
    (!run && start && x_in == '0 && y_in == '0) |=> (!run && phase == '0))
    else $error("zero vector must give zero phase at once");

endmodule
`default_nettype wire

/* sv/fundamental_phasor_estimator_core.sv */
// Top level: sample ring, DFT bin-1 sequencer and per-channel phasor output.
//
//  channel   dir  tdata bits (lowest first)                         tuser/tlast
//  s_axis    in   sample_ch0..sample_ch7, 32 bits each (256)         -
//  m_axis    out  channel_index 3, magnitude 40, phase_angle 16, 0s  tlast=last_of_run
//
// After reset the ring is zeroed, one word a cycle, all WINDOW_SAMPLES*CHANNEL_COUNT
// words (640 by default), before the first word is taken.
// A set without an estimate makes one RAM write per channel.
// An estimate reads every ring word and takes its cosine and sine products on the
// shared multiplier, then per channel sums the squares of re and im, starts the
// root/divide unit and the CORDIC, waits until both are idle and emits the word.
// Output stalls hold the sequencer; a finished result waits in the output register.
`default_nettype none
module fundamental_phasor_estimator_core #(
  parameter int WINDOW_SAMPLES = fpe_pkg::DEF_WINDOW_SAMPLES,
  parameter int CHANNEL_COUNT = fpe_pkg::DEF_CHANNEL_COUNT,
  parameter int ESTIMATES_PER_WINDOW = fpe_pkg::DEF_ESTIMATES_PER_WINDOW
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_ch0 [31:0] .. sample_ch7 [255:224]
  input  wire logic [fpe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // channel_index [2:0], magnitude [42:3], phase_angle [58:43], zero [63:59]
  output logic      [fpe_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import fpe_pkg::*;

  localparam int RUN_PERIOD = (WINDOW_SAMPLES / ESTIMATES_PER_WINDOW) != 0 ?
                              (WINDOW_SAMPLES / ESTIMATES_PER_WINDOW) : 1;
  localparam int DEPTH = WINDOW_SAMPLES * CHANNEL_COUNT;
  localparam int AW = $clog2(DEPTH);
  localparam int ROW_W = $clog2(WINDOW_SAMPLES);
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int RUN_W = $clog2(RUN_PERIOD + 1);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WR = 4'd2;
  localparam logic [3:0] S_RD = 4'd3;
  localparam logic [3:0] S_MC = 4'd4;
  localparam logic [3:0] S_MS = 4'd5;
  localparam logic [3:0] S_MA = 4'd6;
  localparam logic [3:0] S_SQ = 4'd7;
  localparam logic [3:0] S_GO = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0]           state;
  logic [AW-1:0]        addr;
  logic [AW-1:0]        wbase;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     wpos;
  logic [CH_W-1:0]      ch;
  logic [RUN_W-1:0]     run_cnt;
  logic [2:0]           sq_step;
  logic [S_TDATA_W-1:0] samples;
  logic [RAD_W-1:0]     sumsq;
  logic signed [ACC_W-1:0] re_acc [CHANNEL_COUNT];
  logic signed [ACC_W-1:0] im_acc [CHANNEL_COUNT];
  logic                 mvalid;
  logic [M_TDATA_W-1:0] mdata;
  logic                 mlast;

  logic signed [TW_W-1:0] cos_tab [WINDOW_SAMPLES];
  logic signed [TW_W-1:0] sin_tab [WINDOW_SAMPLES];

  logic                    we;
  logic [SAMPLE_W-1:0]     wdata;
  logic [SAMPLE_W-1:0]     rdata;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] re_cur;
  logic signed [ACC_W-1:0] im_cur;
  logic [ACC_W-1:0]        re_abs;
  logic [ACC_W-1:0]        im_abs;
  logic [RAD_W-1:0]        sq_term;
  logic                    root_busy;
  logic                    cordic_busy;
  logic [MAG_W-1:0]        magnitude;
  logic [PHASE_W-1:0]      phase;
  logic                    last_ch;
  logic                    out_free;

  for (genvar gi = 0; gi < WINDOW_SAMPLES; gi++) begin : g_tw
    localparam int ANG = (gi * 65536 + WINDOW_SAMPLES / 2) / WINDOW_SAMPLES;
    localparam logic [2*TW_W-1:0] TW = twiddle_fn(ANG);
    assign cos_tab[gi] = TW[TW_W-1:0];
    assign sin_tab[gi] = TW[2*TW_W-1:TW_W];
  end

  fpe_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  fpe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  fpe_root #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_root (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_GO),
    .radicand  ({sumsq[RAD_W-2:0], 1'b0}),
    .busy      (root_busy),
    .magnitude (magnitude)
  );

  fpe_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GO),
    .y_in  (re_cur),
    .x_in  (im_cur),
    .busy  (cordic_busy),
    .phase (phase)
  );

  assign re_cur = re_acc[ch];
  assign im_cur = im_acc[ch];
  assign re_abs = re_cur[ACC_W-1] ? -re_cur : re_cur;
  assign im_abs = im_cur[ACC_W-1] ? -im_cur : im_cur;
  assign last_ch = (ch == CH_W'(CHANNEL_COUNT - 1));
  assign out_free = !mvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = mvalid;
  assign m_axis_tdata = mdata;
  assign m_axis_tlast = mlast;

  always_comb begin
    we = (state == S_CLR) || (state == S_WR);
    wdata = (state == S_WR) ? samples[ch*SAMPLE_W +: SAMPLE_W] : '0;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = MUL_W'(signed'(rdata));
    mul_b = MUL_W'(cos_tab[row]);
    case (state)
      S_MS: mul_b = MUL_W'(sin_tab[row]);
      S_SQ: begin
        case (sq_step)
          3'd0: begin
            mul_a = MUL_W'(re_abs[HALF_W-1:0]);
            mul_b = MUL_W'(re_abs[HALF_W-1:0]);
          end
          3'd1: begin
            mul_a = MUL_W'(re_abs[HALF_W-1:0]);
            mul_b = MUL_W'(re_abs[ABS_W-1:HALF_W]);
          end
          3'd2: begin
            mul_a = MUL_W'(re_abs[ABS_W-1:HALF_W]);
            mul_b = MUL_W'(re_abs[ABS_W-1:HALF_W]);
          end
          3'd3: begin
            mul_a = MUL_W'(im_abs[HALF_W-1:0]);
            mul_b = MUL_W'(im_abs[HALF_W-1:0]);
          end
          3'd4: begin
            mul_a = MUL_W'(im_abs[HALF_W-1:0]);
            mul_b = MUL_W'(im_abs[ABS_W-1:HALF_W]);
          end
          default: begin
            mul_a = MUL_W'(im_abs[ABS_W-1:HALF_W]);
            mul_b = MUL_W'(im_abs[ABS_W-1:HALF_W]);
          end
        endcase
      end
      default: ;
    endcase
  end

  // weight the previous partial product: low*low, 2*low*high, high*high
  always_comb begin
    case (sq_step)
      3'd2, 3'd5: sq_term = RAD_W'(prod[2*HALF_W-1:0]) << (HALF_W + 1);
      3'd3, 3'd6: sq_term = RAD_W'(prod[2*HALF_W-1:0]) << (2 * HALF_W);
      default: sq_term = RAD_W'(prod[2*HALF_W-1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      addr <= '0;
      wbase <= '0;
      wpos <= '0;
      run_cnt <= '0;
      ch <= '0;
      mvalid <= 1'b0;
    end else begin
      if (mvalid && m_axis_tready) begin
        mvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (addr == AW'(DEPTH - 1)) begin
            addr <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            samples <= s_axis_tdata;
            ch <= '0;
            addr <= wbase;
            state <= S_WR;
          end
        end
        S_WR: begin
          addr <= addr + 1'b1;
          if (last_ch) begin
            ch <= '0;
            if (wpos == ROW_W'(WINDOW_SAMPLES - 1)) begin
              wpos <= '0;
              wbase <= '0;
              run_cnt <= '0;
            end else begin
              wpos <= wpos + 1'b1;
              wbase <= addr + 1'b1;
              run_cnt <= (run_cnt == RUN_W'(RUN_PERIOD - 1)) ? '0 : run_cnt + 1'b1;
            end
            if (run_cnt == '0) begin
              addr <= '0;
              row <= '0;
              for (int c = 0; c < CHANNEL_COUNT; c++) begin
                re_acc[c] <= '0;
                im_acc[c] <= '0;
              end
              state <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            ch <= ch + 1'b1;
          end
        end
        S_RD: state <= S_MC;
        S_MC: state <= S_MS;
        S_MS: begin
          re_acc[ch] <= re_acc[ch] + prod[ACC_W-1:0];
          state <= S_MA;
        end
        S_MA: begin
          im_acc[ch] <= im_acc[ch] - prod[ACC_W-1:0];
          addr <= addr + 1'b1;
          state <= S_RD;
          if (last_ch) begin
            ch <= '0;
            if (row == ROW_W'(WINDOW_SAMPLES - 1)) begin
              sq_step <= '0;
              state <= S_SQ;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            ch <= ch + 1'b1;
          end
        end
        S_SQ: begin
          if (sq_step == 3'd1) begin
            sumsq <= sq_term;
          end else if (sq_step != 3'd0) begin
            sumsq <= sumsq + sq_term;
          end
          if (sq_step == 3'd6) begin
            state <= S_GO;
          end else begin
            sq_step <= sq_step + 1'b1;
          end
        end
        S_GO: state <= S_WAIT;
        S_WAIT: begin
          if (!root_busy && !cordic_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            mvalid <= 1'b1;
            mdata <= {{(M_TDATA_W - CH_IDX_W - MAG_W - PHASE_W){1'b0}},
                      phase, magnitude, CH_IDX_W'(ch)};
            mlast <= last_ch;
            if (last_ch) begin
              ch <= '0;
              state <= S_IDLE;
            end else begin
              ch <= ch + 1'b1;
              sq_step <= '0;
              state <= S_SQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !s_axis_tready)
    else $error("input taken during ring clear");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == 3'(CHANNEL_COUNT - 1)))
    else $error("last flag on wrong channel");

  assert property (@(posedge clk) disable iff (rst)
    (wpos < ROW_W'(WINDOW_SAMPLES)) && (run_cnt < RUN_W'(RUN_PERIOD)))
    else $error("write position or run counter out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> (state == S_OUT))
    else $error("result lost under output stall");

endmodule
`default_nettype wire

/* tb/fundamental_phasor_estimator_core_test.sv */
// Self-checking testbench for the fundamental phasor estimator core.
`default_nettype none
module fundamental_phasor_estimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = fpe_pkg::DEF_WINDOW_SAMPLES;
  localparam int CHANNELS = fpe_pkg::DEF_CHANNEL_COUNT;
  localparam int RUN_PERIOD = fpe_pkg::DEF_WINDOW_SAMPLES / fpe_pkg::DEF_ESTIMATES_PER_WINDOW;
  localparam int LONG_HOLD = 5000;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [fpe_pkg::CH_IDX_W-1:0] channel_index;
    logic [fpe_pkg::MAG_W-1:0]    magnitude;
    logic [fpe_pkg::PHASE_W-1:0]  phase_angle;
    logic                         last_of_run;
  } phasor_t;

  typedef int sample_set_t[CHANNELS];

  class phasor_scoreboard;
    int ring[WINDOW][CHANNELS];
    int row;
    int cos_q15[WINDOW];
    int sin_q15[WINDOW];
    phasor_t pending_phasors[$];
    int mismatches;
    int phasors_seen;
    int runs_predicted;
    int sets_noted;

    function new();
      int ang;
      int arc[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      longint z, x, y, dx, dy;
      bit flip;
      foreach (ring[n, c]) ring[n][c] = 0;
      row = 0;
      mismatches = 0;
      phasors_seen = 0;
      runs_predicted = 0;
      sets_noted = 0;
      // Twiddles by rotation CORDIC in Q2.30, rounded to Q1.15
      for (int n = 0; n < WINDOW; n++) begin
        ang = (n * 65536 + WINDOW / 2) / WINDOW;
        z = ang & 65535;
        flip = 0;
        x = fpe_pkg::CORDIC_START;
        y = 0;
        if (z >= 32768) z -= 65536;
        if (z > 16384) begin
          z -= 32768;
          flip = 1;
        end else if (z < -16384) begin
          z += 32768;
          flip = 1;
        end
        for (int i = 0; i < 15; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= arc[i];
          end else begin
            x += dx; y -= dy; z += arc[i];
          end
        end
        if (flip) begin
          x = -x; y = -y;
        end
        cos_q15[n] = round_q15(x);
        sin_q15[n] = round_q15(y);
      end
    endfunction

    function int round_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
    endfunction

    function logic [39:0] magnitude_of(longint re, longint im);
      logic [127:0] sum, trial;
      logic [63:0] a, b, root, q;
      a = re < 0 ? -re : re;
      b = im < 0 ? -im : im;
      sum = ({64'd0, a} * {64'd0, a} + {64'd0, b} * {64'd0, b}) << 1;
      root = 0;
      for (int k = 56; k >= 0; k--) begin
        trial = {64'd0, root | (64'd1 << k)};
        if (trial * trial <= sum) root |= 64'd1 << k;
      end
      q = (root + 64 * WINDOW) / (128 * WINDOW);
      return q > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : q[39:0];
    endfunction

    function logic [15:0] phase_of(longint y, longint x);
      int arc[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      logic [31:0] z;
      longint dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
        x = -x; y = -y; z = 32768;
      end
      for (int i = 0; i < 15; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += arc[i];
        end else begin
          x -= dx; y += dy; z -= arc[i];
        end
      end
      return z[15:0];
    endfunction

    // Store one accepted sample set; queue a full run of phasors when one is due.
    function void note_set(sample_set_t smp);
      longint re[CHANNELS], im[CHANNELS];
      phasor_t p;
      sets_noted++;
      for (int c = 0; c < CHANNELS; c++) ring[row][c] = smp[c];
      if (row % RUN_PERIOD == 0) begin
        runs_predicted++;
        for (int c = 0; c < CHANNELS; c++) begin
          re[c] = 0; im[c] = 0;
        end
        for (int n = 0; n < WINDOW; n++)
          for (int c = 0; c < CHANNELS; c++) begin
            re[c] += longint'(ring[n][c]) * cos_q15[n];
            im[c] -= longint'(ring[n][c]) * sin_q15[n];
          end
        for (int c = 0; c < CHANNELS; c++) begin
          p.channel_index = 3'(c);
          p.magnitude = magnitude_of(re[c], im[c]);
          p.phase_angle = phase_of(re[c], im[c]);
          p.last_of_run = (c == CHANNELS - 1);
          pending_phasors.push_back(p);
        end
      end
      row = (row + 1 >= WINDOW) ? 0 : row + 1;
    endfunction

    function void check_phasor(logic [63:0] word, logic last);
      phasor_t exp_p;
      phasors_seen++;
      if (pending_phasors.size() == 0) begin
        $error("phasor word %h with none expected", word);
        mismatches++;
        return;
      end
      exp_p = pending_phasors.pop_front();
      if (word[2:0] !== exp_p.channel_index) begin
        $error("channel_index: expected %0d, got %0d", exp_p.channel_index, word[2:0]);
        mismatches++;
      end
      if (word[42:3] !== exp_p.magnitude) begin
        $error("magnitude: expected %0d, got %0d", exp_p.magnitude, word[42:3]);
        mismatches++;
      end
      if (word[58:43] !== exp_p.phase_angle) begin
        $error("phase_angle: expected %0d, got %0d",
               $signed(exp_p.phase_angle), $signed(word[58:43]));
        mismatches++;
      end
      if (word[63:59] !== 5'd0) begin
        $error("pad bits: expected 0, got %h", word[63:59]);
        mismatches++;
      end
      if (last !== exp_p.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp_p.last_of_run, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [fpe_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [fpe_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  phasor_scoreboard sb = new();
  bit quiet = 0;
  bit hold_request = 0;
  longint cycles = 0;

  fundamental_phasor_estimator_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("fundamental_phasor_estimator_core_test: FAIL");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_phasor(m_axis_tdata, m_axis_tlast);
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready <= 0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_set(sample_set_t smp);
    logic [fpe_pkg::S_TDATA_W-1:0] word;
    for (int c = 0; c < CHANNELS; c++) word[c*32 +: 32] = smp[c];
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tdata <= word;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_set(smp);
    @(negedge clk);
  endtask

  task automatic send_uniform(int v);
    sample_set_t smp;
    foreach (smp[c]) smp[c] = v;
    send_set(smp);
  endtask

  task automatic send_random();
    sample_set_t smp;
    int mode;
    foreach (smp[c]) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) smp[c] = $urandom;
      else if (mode < 8) smp[c] = $signed($urandom_range(0, 2000)) - 1000;
      else smp[c] = mode == 8 ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    send_set(smp);
  endtask

  initial begin
    sample_set_t smp;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: all-zero first set gives a zero vector on every channel
    send_uniform(0);
    send_uniform(32'h7FFF_FFFF);
    send_uniform(32'h8000_0000);
    send_uniform(1);
    send_uniform(-1);
    foreach (smp[c]) smp[c] = c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_set(smp);
    for (int k = 0; k < CHANNELS; k++) begin
      foreach (smp[c]) smp[c] = (c == k) ? 32'h7FFF_FFFF : 0;
      send_set(smp);
    end
    for (int k = 0; k < 6; k++) send_uniform(k[0] ? -12345 : 12345);
    // This set lands on row 20 and triggers a run over the extremes above
    send_uniform(32'h8000_0000);

    for (int i = 0; i < 150; i++) begin
      if (i == 30) hold_request = 1;
      if (i == 80) begin
        s_axis_tvalid <= 0;
        wait (sb.pending_phasors.size() == 0);
        @(negedge clk);
      end
      if (i == 120) quiet = 1;
      send_random();
    end
    s_axis_tvalid <= 0;

    wait (sb.pending_phasors.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d sample sets, %0d estimate runs, %0d phasors checked",
             sb.sets_noted, sb.runs_predicted, sb.phasors_seen);
    if (sb.mismatches == 0 && sb.pending_phasors.size() == 0) begin
      $display("fundamental_phasor_estimator_core_test: PASS");
    end else begin
      $display("%0d mismatches, %0d phasors missing",
               sb.mismatches, sb.pending_phasors.size());
      $display("fundamental_phasor_estimator_core_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
